// ===== src/ihl_pkg.sv =====
// shared constants, codes and types for the indexed max-heap leader timer
`timescale 1ns / 1ps
package ihl_pkg;

  // sizes
  localparam int MAX_BINS   = 256;
  localparam int MAX_OWNERS = 1024;
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int OWN_W      = $clog2(MAX_OWNERS);
  localparam int CNT_W      = BIN_W + 1;
  localparam int WGT_W      = 32;
  localparam int TIME_W     = 32;
  localparam int BW_W       = WGT_W + OWN_W;
  localparam int OP_W       = 2;
  localparam int ST_W       = 3;
  localparam int ALU_W      = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_UNKNOWN   = 3'd1;
  localparam logic [ST_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [ST_W-1:0] ST_BACKWARDS = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

  // shared unit functions
  localparam logic [ALU_W-1:0] ALU_ADD = 2'd0;
  localparam logic [ALU_W-1:0] ALU_SUB = 2'd1;
  localparam logic [ALU_W-1:0] ALU_SAT = 2'd2;

  // one owner table entry
  typedef struct packed {
    logic              present;
    logic [WGT_W-1:0]  weight;
    logic [BIN_W-1:0]  bin;
  } owner_rec_t;

endpackage

// ===== src/ihl_ram.sv =====
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps
module ihl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, data holds between reads
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== src/ihl_alu.sv =====
// shared add, subtract, saturating add and compare unit
`timescale 1ns / 1ps
module ihl_alu (
  input  logic [ihl_pkg::ALU_W-1:0] op,
  input  logic [ihl_pkg::BW_W-1:0]  a,
  input  logic [ihl_pkg::BW_W-1:0]  b,
  output logic [ihl_pkg::BW_W-1:0]  res,
  output logic                      lt
);
  import ihl_pkg::*;

  logic [TIME_W:0] sat_sum;

  // 32-bit sum with carry for saturation
  assign sat_sum = {1'b0, a[TIME_W-1:0]} + {1'b0, b[TIME_W-1:0]};

  always_comb begin
    unique case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      ALU_SAT: res = sat_sum[TIME_W] ? BW_W'({TIME_W{1'b1}})
                                     : BW_W'(sat_sum[TIME_W-1:0]);
      default: res = a;
    endcase
  end

  assign lt = a < b;

endmodule

// ===== src/indexed_max_heap_leader_time.sv =====
// indexed max-heap of bins that credits elapsed time to the unique heaviest bin
//
//   channel  | ports                                   | transfer
//   ---------+-----------------------------------------+---------------------------
//   command  | start, busy, in_*                       | start high while busy low
//   result   | out_valid, out_credited_time, out_status| one cycle while out_valid
//
// A command passes, as its operation needs, through decode, owner lookup, the
// root check, the bin updates and the result; a move also sifts the weight
// down out of its old bin and up into the new one, one heap level at a time,
// paced by the single compare unit and the one-read-per-cycle bin memories,
// and each sift ends with a settling step. After reset the owner table is
// cleared, one entry per cycle, while busy is high. The result strobe is one
// cycle and the receiver cannot hold it off.
`timescale 1ns / 1ps
module indexed_max_heap_leader_time (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ihl_pkg::OP_W-1:0]   in_operation,
  input  logic [ihl_pkg::OWN_W-1:0]  in_owner_index,
  input  logic [ihl_pkg::BIN_W-1:0]  in_bin_index,
  input  logic [ihl_pkg::WGT_W-1:0]  in_weight,
  input  logic [ihl_pkg::TIME_W-1:0] in_event_time,
  output logic                       out_valid,
  output logic [ihl_pkg::TIME_W-1:0] out_credited_time,
  output logic [ihl_pkg::ST_W-1:0]   out_status
);
  import ihl_pkg::*;

  // sequencer states
  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_OWN   = 5'd3;
  localparam logic [4:0] S_C0    = 5'd4;
  localparam logic [4:0] S_C1    = 5'd5;
  localparam logic [4:0] S_C2    = 5'd6;
  localparam logic [4:0] S_C3    = 5'd7;
  localparam logic [4:0] S_C4    = 5'd8;
  localparam logic [4:0] S_LV0   = 5'd9;
  localparam logic [4:0] S_LV1   = 5'd10;
  localparam logic [4:0] S_D_RD  = 5'd11;
  localparam logic [4:0] S_D_W   = 5'd12;
  localparam logic [4:0] S_D_CL  = 5'd13;
  localparam logic [4:0] S_D_CR  = 5'd14;
  localparam logic [4:0] S_JN0   = 5'd15;
  localparam logic [4:0] S_JN1   = 5'd16;
  localparam logic [4:0] S_U_RD  = 5'd17;
  localparam logic [4:0] S_U_W   = 5'd18;
  localparam logic [4:0] S_U_CMP = 5'd19;
  localparam logic [4:0] S_OWR   = 5'd20;
  localparam logic [4:0] S_RDB   = 5'd21;
  localparam logic [4:0] S_DONE  = 5'd22;

  localparam int OWN_REC_W = $bits(owner_rec_t);

  // control registers
  logic [4:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TIME_W-1:0]   prev_r, prev_nxt;
  logic [MAX_BINS-1:0] present_r;
  logic                present_set;
  logic [OWN_W-1:0]    clr_r;

  // payload registers
  logic [OP_W-1:0]     op_r;
  logic [OWN_W-1:0]    owner_r;
  logic [BIN_W-1:0]    bin_r;
  logic [WGT_W-1:0]    wt_r;
  logic [TIME_W-1:0]   tm_r;
  logic [TIME_W-1:0]   amt_r, amt_nxt;
  logic [WGT_W-1:0]    mw_r, mw_nxt;
  logic [BIN_W-1:0]    ob_r, ob_nxt;
  logic [BIN_W-1:0]    lead_r, lead_nxt;
  logic [BW_W-1:0]     w0_r, w0_nxt;
  logic [BW_W-1:0]     cw_r, cw_nxt;
  logic [BIN_W-1:0]    cb_r, cb_nxt;
  logic [BIN_W-1:0]    p_r, p_nxt;
  logic [BIN_W-1:0]    par_r, par_nxt;
  logic [BIN_W-1:0]    lb_r, lb_nxt;
  logic [BIN_W-1:0]    rb_r, rb_nxt;
  logic [BW_W-1:0]     bestw_r, bestw_nxt;
  logic                best_l_r, best_l_nxt;
  logic [BIN_W-1:0]    pb_r, pb_nxt;
  logic [ST_W-1:0]     status_r, status_nxt;
  logic [TIME_W-1:0]   cred_r, cred_nxt;

  // memory ports
  logic                  own_we, own_re;
  logic [OWN_W-1:0]      own_waddr, own_raddr;
  owner_rec_t            own_wrec, own_rrec;
  logic [OWN_REC_W-1:0]  own_q;

  logic                  slot_we, slot_a_re, slot_b_re;
  logic [BIN_W-1:0]      slot_waddr, slot_wdata, slot_a_raddr, slot_b_raddr;
  logic [BIN_W-1:0]      slot_a_q, slot_b_q;

  logic                  bw_we, bw_a_re, bw_b_re;
  logic [BIN_W-1:0]      bw_waddr, bw_a_raddr, bw_b_raddr;
  logic [BW_W-1:0]       bw_wdata, bw_a_q, bw_b_q;

  logic                  bt_we, bt_re;
  logic [BIN_W-1:0]      bt_waddr, bt_raddr;
  logic [TIME_W-1:0]     bt_wdata, bt_q;

  logic                  bpos_we, bpos_re;
  logic [BIN_W-1:0]      bpos_waddr, bpos_wdata, bpos_raddr, bpos_q;

  // shared unit
  logic [ALU_W-1:0]      alu_op;
  logic [BW_W-1:0]       alu_a, alu_b, alu_res;
  logic                  alu_lt;

  // child indexes for sift-down
  logic [CNT_W-1:0]      left_idx, right_idx;

  logic                  accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_credited_time = cred_r;
  assign out_status        = status_r;

  assign own_rrec  = owner_rec_t'(own_q);
  assign left_idx  = {p_r, 1'b1};
  assign right_idx = {p_r, 1'b0} + CNT_W'(2);

  ihl_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt)
  );

  // owner table
  ihl_ram #(.WIDTH(OWN_REC_W), .DEPTH(MAX_OWNERS)) u_own (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(OWN_REC_W'(own_wrec)),
    .re(own_re), .raddr(own_raddr), .rdata(own_q)
  );

  // heap slot to bin, two copies for two reads per cycle
  ihl_ram #(.WIDTH(BIN_W), .DEPTH(MAX_BINS)) u_slot_a (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_a_re), .raddr(slot_a_raddr), .rdata(slot_a_q)
  );
  ihl_ram #(.WIDTH(BIN_W), .DEPTH(MAX_BINS)) u_slot_b (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_b_re), .raddr(slot_b_raddr), .rdata(slot_b_q)
  );

  // bin weight, two copies for two reads per cycle
  ihl_ram #(.WIDTH(BW_W), .DEPTH(MAX_BINS)) u_bw_a (
    .clk(clk), .we(bw_we), .waddr(bw_waddr), .wdata(bw_wdata),
    .re(bw_a_re), .raddr(bw_a_raddr), .rdata(bw_a_q)
  );
  ihl_ram #(.WIDTH(BW_W), .DEPTH(MAX_BINS)) u_bw_b (
    .clk(clk), .we(bw_we), .waddr(bw_waddr), .wdata(bw_wdata),
    .re(bw_b_re), .raddr(bw_b_raddr), .rdata(bw_b_q)
  );

  // bin credited time
  ihl_ram #(.WIDTH(TIME_W), .DEPTH(MAX_BINS)) u_bt (
    .clk(clk), .we(bt_we), .waddr(bt_waddr), .wdata(bt_wdata),
    .re(bt_re), .raddr(bt_raddr), .rdata(bt_q)
  );

  // bin heap position
  ihl_ram #(.WIDTH(BIN_W), .DEPTH(MAX_BINS)) u_bpos (
    .clk(clk), .we(bpos_we), .waddr(bpos_waddr), .wdata(bpos_wdata),
    .re(bpos_re), .raddr(bpos_raddr), .rdata(bpos_q)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    prev_nxt    = prev_r;
    present_set = 1'b0;
    amt_nxt     = amt_r;
    mw_nxt      = mw_r;
    ob_nxt      = ob_r;
    lead_nxt    = lead_r;
    w0_nxt      = w0_r;
    cw_nxt      = cw_r;
    cb_nxt      = cb_r;
    p_nxt       = p_r;
    par_nxt     = par_r;
    lb_nxt      = lb_r;
    rb_nxt      = rb_r;
    bestw_nxt   = bestw_r;
    best_l_nxt  = best_l_r;
    pb_nxt      = pb_r;
    status_nxt  = status_r;
    cred_nxt    = cred_r;

    own_we = 1'b0;  own_waddr = owner_r;  own_wrec = '0;
    own_re = 1'b0;  own_raddr = owner_r;
    slot_we = 1'b0; slot_waddr = p_r; slot_wdata = cb_r;
    slot_a_re = 1'b0; slot_a_raddr = '0;
    slot_b_re = 1'b0; slot_b_raddr = '0;
    bw_we = 1'b0; bw_waddr = bin_r; bw_wdata = alu_res;
    bw_a_re = 1'b0; bw_a_raddr = bin_r;
    bw_b_re = 1'b0; bw_b_raddr = bin_r;
    bt_we = 1'b0; bt_waddr = lead_r; bt_wdata = alu_res[TIME_W-1:0];
    bt_re = 1'b0; bt_raddr = bin_r;
    bpos_we = 1'b0; bpos_waddr = cb_r; bpos_wdata = p_r;
    bpos_re = 1'b0; bpos_raddr = bin_r;

    alu_op = ALU_SUB;
    alu_a  = BW_W'(tm_r);
    alu_b  = BW_W'(prev_r);

    unique case (state_r)
      // clear the owner table after reset
      S_CLR: begin
        own_we    = 1'b1;
        own_waddr = clr_r;
        if (clr_r == OWN_W'(MAX_OWNERS - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          cred_nxt   = '0;
          state_nxt  = S_DEC;
        end
      end

      // time check and first lookups
      S_DEC: begin
        amt_nxt = alu_res[TIME_W-1:0];
        unique case (op_r)
          OP_ADD: begin
            own_re    = 1'b1;
            state_nxt = S_OWN;
          end
          OP_MOVE, OP_FINISH: begin
            if (alu_lt) begin
              status_nxt = ST_BACKWARDS;
              state_nxt  = S_DONE;
            end else if (op_r == OP_MOVE) begin
              own_re    = 1'b1;
              state_nxt = S_OWN;
            end else begin
              state_nxt = S_C0;
            end
          end
          default: begin
            if (present_r[bin_r]) begin
              bt_re     = 1'b1;
              state_nxt = S_RDB;
            end else begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end

      // owner entry is back
      S_OWN: begin
        if (op_r == OP_ADD) begin
          if (own_rrec.present) begin
            status_nxt = ST_EXISTS;
            state_nxt  = S_DONE;
          end else begin
            mw_nxt    = wt_r;
            state_nxt = S_JN0;
          end
        end else begin
          if (!own_rrec.present) begin
            status_nxt = ST_UNKNOWN;
            state_nxt  = S_DONE;
          end else begin
            mw_nxt    = own_rrec.weight;
            ob_nxt    = own_rrec.bin;
            state_nxt = S_C0;
          end
        end
      end

      // root check: read the top three slots
      S_C0: begin
        if (cnt_r == '0) begin
          prev_nxt  = tm_r;
          state_nxt = (op_r == OP_MOVE) ? S_LV0 : S_DONE;
        end else begin
          slot_a_re    = 1'b1;
          slot_a_raddr = '0;
          slot_b_re    = 1'b1;
          slot_b_raddr = BIN_W'(1);
          state_nxt    = S_C1;
        end
      end

      S_C1: begin
        lead_nxt     = slot_a_q;
        bw_a_re      = 1'b1;
        bw_a_raddr   = slot_a_q;
        bw_b_re      = 1'b1;
        bw_b_raddr   = slot_b_q;
        slot_a_re    = 1'b1;
        slot_a_raddr = BIN_W'(2);
        state_nxt    = S_C2;
      end

      // left child against root
      S_C2: begin
        w0_nxt = bw_a_q;
        alu_a  = bw_b_q;
        alu_b  = bw_a_q;
        if (cnt_r > CNT_W'(1) && !alu_lt) begin
          prev_nxt  = tm_r;
          state_nxt = (op_r == OP_MOVE) ? S_LV0 : S_DONE;
        end else begin
          bw_a_re    = 1'b1;
          bw_a_raddr = slot_a_q;
          state_nxt  = S_C3;
        end
      end

      // right child against root
      S_C3: begin
        alu_a = bw_a_q;
        alu_b = w0_r;
        if (cnt_r > CNT_W'(2) && !alu_lt) begin
          prev_nxt  = tm_r;
          state_nxt = (op_r == OP_MOVE) ? S_LV0 : S_DONE;
        end else begin
          bt_re     = 1'b1;
          bt_raddr  = lead_r;
          state_nxt = S_C4;
        end
      end

      // saturating credit to the leader
      S_C4: begin
        alu_op    = ALU_SAT;
        alu_a     = BW_W'(bt_q);
        alu_b     = BW_W'(amt_r);
        bt_we     = 1'b1;
        bt_waddr  = lead_r;
        prev_nxt  = tm_r;
        state_nxt = (op_r == OP_MOVE) ? S_LV0 : S_DONE;
      end

      // weight leaves the old bin
      S_LV0: begin
        bw_a_re    = 1'b1;
        bw_a_raddr = ob_r;
        bpos_re    = 1'b1;
        bpos_raddr = ob_r;
        state_nxt  = S_LV1;
      end

      S_LV1: begin
        alu_op    = ALU_SUB;
        alu_a     = bw_a_q;
        alu_b     = BW_W'(mw_r);
        bw_we     = 1'b1;
        bw_waddr  = ob_r;
        cw_nxt    = alu_res;
        cb_nxt    = ob_r;
        p_nxt     = bpos_q;
        state_nxt = S_D_RD;
      end

      // sift down: fetch children or settle
      S_D_RD: begin
        if (left_idx >= cnt_r) begin
          slot_we   = 1'b1;
          bpos_we   = 1'b1;
          state_nxt = S_JN0;
        end else begin
          slot_a_re    = 1'b1;
          slot_a_raddr = left_idx[BIN_W-1:0];
          slot_b_re    = 1'b1;
          slot_b_raddr = right_idx[BIN_W-1:0];
          state_nxt    = S_D_W;
        end
      end

      S_D_W: begin
        lb_nxt     = slot_a_q;
        rb_nxt     = slot_b_q;
        bw_a_re    = 1'b1;
        bw_a_raddr = slot_a_q;
        bw_b_re    = 1'b1;
        bw_b_raddr = slot_b_q;
        state_nxt  = S_D_CL;
      end

      S_D_CL: begin
        alu_a = cw_r;
        alu_b = bw_a_q;
        if (alu_lt) begin
          best_l_nxt = 1'b1;
          bestw_nxt  = bw_a_q;
        end else begin
          best_l_nxt = 1'b0;
          bestw_nxt  = cw_r;
        end
        state_nxt = S_D_CR;
      end

      S_D_CR: begin
        alu_a = bestw_r;
        alu_b = bw_b_q;
        priority if (right_idx < cnt_r && alu_lt) begin
          slot_we    = 1'b1;
          slot_wdata = rb_r;
          bpos_we    = 1'b1;
          bpos_waddr = rb_r;
          p_nxt      = right_idx[BIN_W-1:0];
          state_nxt  = S_D_RD;
        end else if (best_l_r) begin
          slot_we    = 1'b1;
          slot_wdata = lb_r;
          bpos_we    = 1'b1;
          bpos_waddr = lb_r;
          p_nxt      = left_idx[BIN_W-1:0];
          state_nxt  = S_D_RD;
        end else begin
          slot_we   = 1'b1;
          bpos_we   = 1'b1;
          state_nxt = S_JN0;
        end
      end

      // weight joins the target bin
      S_JN0: begin
        bw_a_re    = 1'b1;
        bw_a_raddr = bin_r;
        bpos_re    = 1'b1;
        bpos_raddr = bin_r;
        state_nxt  = S_JN1;
      end

      S_JN1: begin
        alu_op   = ALU_ADD;
        alu_a    = present_r[bin_r] ? bw_a_q : '0;
        alu_b    = BW_W'(mw_r);
        bw_we    = 1'b1;
        bw_waddr = bin_r;
        cw_nxt   = alu_res;
        cb_nxt   = bin_r;
        if (present_r[bin_r]) begin
          p_nxt = bpos_q;
        end else begin
          p_nxt       = cnt_r[BIN_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
          present_set = 1'b1;
          bt_we       = 1'b1;
          bt_waddr    = bin_r;
          bt_wdata    = '0;
        end
        state_nxt = S_U_RD;
      end

      // sift up: fetch parent or settle
      S_U_RD: begin
        if (p_r == '0) begin
          slot_we   = 1'b1;
          bpos_we   = 1'b1;
          state_nxt = S_OWR;
        end else begin
          par_nxt      = (p_r - BIN_W'(1)) >> 1;
          slot_a_re    = 1'b1;
          slot_a_raddr = (p_r - BIN_W'(1)) >> 1;
          state_nxt    = S_U_W;
        end
      end

      S_U_W: begin
        pb_nxt     = slot_a_q;
        bw_a_re    = 1'b1;
        bw_a_raddr = slot_a_q;
        state_nxt  = S_U_CMP;
      end

      S_U_CMP: begin
        alu_a = bw_a_q;
        alu_b = cw_r;
        if (alu_lt) begin
          slot_we    = 1'b1;
          slot_wdata = pb_r;
          bpos_we    = 1'b1;
          bpos_waddr = pb_r;
          p_nxt      = par_r;
          state_nxt  = S_U_RD;
        end else begin
          slot_we   = 1'b1;
          bpos_we   = 1'b1;
          state_nxt = S_OWR;
        end
      end

      // record the owner in its new bin
      S_OWR: begin
        own_we           = 1'b1;
        own_wrec.present = 1'b1;
        own_wrec.weight  = mw_r;
        own_wrec.bin     = bin_r;
        state_nxt        = S_DONE;
      end

      S_RDB: begin
        cred_nxt  = bt_q;
        state_nxt = S_DONE;
      end

      S_DONE: state_nxt = S_IDLE;

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cnt_r     <= '0;
      prev_r    <= '0;
      present_r <= '0;
      clr_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      prev_r  <= prev_nxt;
      if (present_set) present_r[bin_r] <= 1'b1;
      if (state_r == S_CLR) clr_r <= clr_r + OWN_W'(1);
    end
  end

  // command capture and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      owner_r <= in_owner_index;
      bin_r   <= in_bin_index;
      wt_r    <= in_weight;
      tm_r    <= in_event_time;
    end
    amt_r    <= amt_nxt;
    mw_r     <= mw_nxt;
    ob_r     <= ob_nxt;
    lead_r   <= lead_nxt;
    w0_r     <= w0_nxt;
    cw_r     <= cw_nxt;
    cb_r     <= cb_nxt;
    p_r      <= p_nxt;
    par_r    <= par_nxt;
    lb_r     <= lb_nxt;
    rb_r     <= rb_nxt;
    bestw_r  <= bestw_nxt;
    best_l_r <= best_l_nxt;
    pb_r     <= pb_nxt;
    status_r <= status_nxt;
    cred_r   <= cred_nxt;
  end

endmodule
